/* sv/state_vector_gate_engine_defines.svh */
// Assertion macros shared by the state vector gate engine checkers
`ifndef STATE_VECTOR_GATE_ENGINE_DEFINES_SVH
`define STATE_VECTOR_GATE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SVGE_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error("svge check failed");

// next-cycle implication, disabled during reset
`define SVGE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error("svge check failed");

`endif

/* sv/svge_pkg.sv */
// Constants, codes and the pair coefficient table of the gate engine
`default_nettype none
package svge_pkg;
	localparam int MAX_QUBITS = 10;
	localparam int AMP_WIDTH  = 24;
	localparam int FRAC_BITS  = AMP_WIDTH - 2;
	localparam int QW         = MAX_QUBITS;
	localparam int DEPTH      = 1 << MAX_QUBITS;
	localparam int CW         = AMP_WIDTH + 1;
	localparam int PW         = CW + AMP_WIDTH;
	localparam int SW         = PW + 1;
	localparam int NQW        = 4;

	// 1/sqrt2 in the amplitude format, rounded
	localparam logic [63:0] RSQRT2_Q32 = 64'd3037000500;
	localparam logic [63:0] RSQRT2_FX64 =
		(RSQRT2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

	localparam logic [1:0] K_LOAD = 2'd0;
	localparam logic [1:0] K_GATE = 2'd1;
	localparam logic [1:0] K_READ = 2'd2;

	localparam logic [4:0] G_I    = 5'd0;
	localparam logic [4:0] G_X    = 5'd1;
	localparam logic [4:0] G_Y    = 5'd2;
	localparam logic [4:0] G_Z    = 5'd3;
	localparam logic [4:0] G_H    = 5'd4;
	localparam logic [4:0] G_S    = 5'd5;
	localparam logic [4:0] G_T    = 5'd6;
	localparam logic [4:0] G_SDG  = 5'd7;
	localparam logic [4:0] G_TDG  = 5'd8;
	localparam logic [4:0] G_RX   = 5'd9;
	localparam logic [4:0] G_RY   = 5'd10;
	localparam logic [4:0] G_RZ   = 5'd11;
	localparam logic [4:0] G_CNOT = 5'd12;
	localparam logic [4:0] G_CZ   = 5'd13;
	localparam logic [4:0] G_CY   = 5'd14;
	localparam logic [4:0] G_SWAP = 5'd15;
	localparam logic [4:0] G_TOF  = 5'd16;
	localparam logic [4:0] G_FRED = 5'd17;

	// coefficient selects
	localparam logic [2:0] X_ZERO = 3'd0;
	localparam logic [2:0] X_ONE  = 3'd1;
	localparam logic [2:0] X_MONE = 3'd2;
	localparam logic [2:0] X_C    = 3'd3;
	localparam logic [2:0] X_S    = 3'd4;
	localparam logic [2:0] X_NS   = 3'd5;
	localparam logic [2:0] X_K    = 3'd6;
	localparam logic [2:0] X_NK   = 3'd7;

	// operand selects
	localparam logic [1:0] Y_AR = 2'd0;
	localparam logic [1:0] Y_AI = 2'd1;
	localparam logic [1:0] Y_BR = 2'd2;
	localparam logic [1:0] Y_BI = 2'd3;

	typedef struct packed {
		logic [2:0] xs;
		logic [1:0] ys;
	} term_t;

	// term j: output j/2 (a_re, a_im, b_re, b_im), product j%2 of its sum
	function automatic term_t pair_term(input logic [4:0] op, input logic [2:0] j);
		term_t t [8];
		t[0] = '{X_ONE, Y_AR}; t[1] = '{X_ZERO, Y_AR};
		t[2] = '{X_ONE, Y_AI}; t[3] = '{X_ZERO, Y_AR};
		t[4] = '{X_ONE, Y_BR}; t[5] = '{X_ZERO, Y_AR};
		t[6] = '{X_ONE, Y_BI}; t[7] = '{X_ZERO, Y_AR};
		case (op)
			G_X: begin
				t[0] = '{X_ONE, Y_BR}; t[2] = '{X_ONE, Y_BI};
				t[4] = '{X_ONE, Y_AR}; t[6] = '{X_ONE, Y_AI};
			end
			G_Y: begin
				t[0] = '{X_ONE, Y_BI};  t[2] = '{X_MONE, Y_BR};
				t[4] = '{X_MONE, Y_AI}; t[6] = '{X_ONE, Y_AR};
			end
			G_Z: begin
				t[4] = '{X_MONE, Y_BR}; t[6] = '{X_MONE, Y_BI};
			end
			G_H: begin
				t[0] = '{X_K, Y_AR}; t[1] = '{X_K, Y_BR};
				t[2] = '{X_K, Y_AI}; t[3] = '{X_K, Y_BI};
				t[4] = '{X_K, Y_AR}; t[5] = '{X_NK, Y_BR};
				t[6] = '{X_K, Y_AI}; t[7] = '{X_NK, Y_BI};
			end
			G_S: begin
				t[4] = '{X_MONE, Y_BI}; t[6] = '{X_ONE, Y_BR};
			end
			G_T: begin
				t[4] = '{X_K, Y_BR}; t[5] = '{X_NK, Y_BI};
				t[6] = '{X_K, Y_BR}; t[7] = '{X_K, Y_BI};
			end
			G_SDG: begin
				t[4] = '{X_ONE, Y_BI}; t[6] = '{X_MONE, Y_BR};
			end
			G_TDG: begin
				t[4] = '{X_K, Y_BR}; t[5] = '{X_K, Y_BI};
				t[6] = '{X_K, Y_BI}; t[7] = '{X_NK, Y_BR};
			end
			G_RX: begin
				t[0] = '{X_C, Y_AR};  t[1] = '{X_S, Y_BI};
				t[2] = '{X_C, Y_AI};  t[3] = '{X_NS, Y_BR};
				t[4] = '{X_S, Y_AI};  t[5] = '{X_C, Y_BR};
				t[6] = '{X_NS, Y_AR}; t[7] = '{X_C, Y_BI};
			end
			G_RY: begin
				t[0] = '{X_C, Y_AR}; t[1] = '{X_NS, Y_BR};
				t[2] = '{X_C, Y_AI}; t[3] = '{X_NS, Y_BI};
				t[4] = '{X_S, Y_AR}; t[5] = '{X_C, Y_BR};
				t[6] = '{X_S, Y_AI}; t[7] = '{X_C, Y_BI};
			end
			G_RZ: begin
				t[0] = '{X_C, Y_AR}; t[1] = '{X_S, Y_AI};
				t[2] = '{X_C, Y_AI}; t[3] = '{X_NS, Y_AR};
				t[4] = '{X_C, Y_BR}; t[5] = '{X_NS, Y_BI};
				t[6] = '{X_C, Y_BI}; t[7] = '{X_S, Y_BR};
			end
			default: begin
			end
		endcase
		return t[j];
	endfunction
endpackage
`default_nettype wire

/* sv/state_vector_gate_engine.sv */
// State vector gate engine: amplitude store, gate sequencer and shared MAC
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------
//  input    | in        | in_valid / in_stall | kind, gate_code, invert, amp_index,
//           |           |                     | load_re/im, control_a/b,
//           |           |                     | target_a/b, coef_cos/sin
//  output   | out       | out_valid/out_stall | read_re, read_im, status
//  config   | in        | cfg_we              | cfg_data (active_qubits)
//
// Load, rejected gate, identity and unknown kind: result the cycle after accept.
// Read: the memory read is registered, then copied into the result registers.
// Gate: scans every amplitude index; each pair is read from memory, the
//   single 25x24 multiplier runs 8 products per pair, then both are written back.
// One request at a time; in_stall is high while busy or while a result waits.
// No clearing pass: unwritten amplitudes read as garbage.
`default_nettype none
module state_vector_gate_engine import svge_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [NQW-1:0]              cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  kind,
	input  wire logic [4:0]                  gate_code,
	input  wire logic                        invert,
	input  wire logic [QW-1:0]               amp_index,
	input  wire logic signed [AMP_WIDTH-1:0] load_re,
	input  wire logic signed [AMP_WIDTH-1:0] load_im,
	input  wire logic [3:0]                  control_a,
	input  wire logic [3:0]                  control_b,
	input  wire logic [3:0]                  target_a,
	input  wire logic [3:0]                  target_b,
	input  wire logic signed [AMP_WIDTH-1:0] coef_cos,
	input  wire logic signed [AMP_WIDTH-1:0] coef_sin,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed [AMP_WIDTH-1:0]      read_re,
	output logic signed [AMP_WIDTH-1:0]      read_im,
	output logic                             status
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SCAN = 4'd1;
	localparam logic [3:0] ST_RDA  = 4'd2;
	localparam logic [3:0] ST_RDB  = 4'd3;
	localparam logic [3:0] ST_CAPB = 4'd4;
	localparam logic [3:0] ST_MUL  = 4'd5;
	localparam logic [3:0] ST_WRA  = 4'd6;
	localparam logic [3:0] ST_WRB  = 4'd7;
	localparam logic [3:0] ST_RDW  = 4'd8;

	localparam logic signed [CW-1:0] ONE_FX = CW'(1) << FRAC_BITS;
	localparam logic signed [CW-1:0] K_FX   = CW'(RSQRT2_FX64);
	localparam logic signed [SW-1:0] HALF   = SW'(1) << (FRAC_BITS - 1);
	localparam logic signed [SW-1:0] AMAX   = SW'({1'b0, {(AMP_WIDTH-1){1'b1}}});
	localparam logic signed [SW-1:0] AMIN   = -AMAX - SW'(1);

	logic [3:0]                  state_q;
	logic [NQW-1:0]              nq_cfg_q;
	logic [2*AMP_WIDTH-1:0]      mem [DEPTH];
	logic [2*AMP_WIDTH-1:0]      rd_q;
	logic [QW-1:0]               i_q, last_q, req1_q, req0_q, flip_q, a_q, b_q;
	logic [4:0]                  op_q;
	logic [3:0]                  j_q;
	logic signed [CW-1:0]        c_q, s_q;
	logic signed [AMP_WIDTH-1:0] ar_q, ai_q, br_q, bi_q;
	logic signed [PW-1:0]        prod_q, acc_q;
	logic signed [AMP_WIDTH-1:0] res_q [4];
	logic                        out_valid_q, status_q;
	logic signed [AMP_WIDTH-1:0] read_re_q, read_im_q;

	logic                        accept, we;
	logic [QW-1:0]               waddr, raddr;
	logic [2*AMP_WIDTH-1:0]      wdata;
	logic [NQW-1:0]              nq;
	logic [QW:0]                 last_w;
	logic [QW-1:0]               mt, mt2, mc, mc2;
	logic                        err, is_pair, last_i;
	logic [4:0]                  op_d;
	logic [QW-1:0]               req1_d, req0_d, flip_d;
	logic signed [CW-1:0]        s_in;
	term_t                       term;
	logic signed [CW-1:0]        xv;
	logic signed [AMP_WIDTH-1:0] yv;
	logic signed [PW-1:0]        xe, ye;
	logic signed [SW-1:0]        sum, shv;
	logic signed [AMP_WIDTH-1:0] rnd;
	logic [2:0]                  tsel;

	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign accept   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign read_re   = read_re_q;
	assign read_im   = read_im_q;
	assign status    = status_q;

	// effective qubit count, clamped into 1..MAX_QUBITS
	always_comb begin
		if (nq_cfg_q == '0) begin
			nq = NQW'(1);
		end else if (nq_cfg_q > NQW'(MAX_QUBITS)) begin
			nq = NQW'(MAX_QUBITS);
		end else begin
			nq = nq_cfg_q;
		end
		last_w = ((QW+1)'(1) << nq) - (QW+1)'(1);
	end

	// operand checks and pair pattern for a gate request
	always_comb begin
		mt  = QW'(1) << target_a;
		mt2 = QW'(1) << target_b;
		mc  = QW'(1) << control_a;
		mc2 = QW'(1) << control_b;
		err = 1'b0;
		if (gate_code > G_FRED || (invert && gate_code == G_CY)) begin
			err = 1'b1;
		end else if (gate_code != G_I) begin
			if (target_a >= nq) err = 1'b1;
			if ((gate_code >= G_CNOT && gate_code <= G_CY) || gate_code == G_TOF ||
			    gate_code == G_FRED) begin
				if (control_a >= nq || control_a == target_a) err = 1'b1;
			end
			if (gate_code == G_SWAP || gate_code == G_FRED) begin
				if (target_b >= nq || target_b == target_a ||
				    (gate_code == G_FRED && target_b == control_a)) err = 1'b1;
			end
			if (gate_code == G_TOF && (control_b >= nq || control_b == target_a ||
			    control_b == control_a)) err = 1'b1;
		end

		op_d = gate_code;
		s_in = CW'(coef_sin);
		if (invert) begin
			case (gate_code)
				G_S:     op_d = G_SDG;
				G_T:     op_d = G_TDG;
				G_SDG:   op_d = G_S;
				G_TDG:   op_d = G_T;
				G_RX, G_RY, G_RZ: s_in = -CW'(coef_sin);
				default: op_d = gate_code;
			endcase
		end

		// pair b = a ^ flip; a needs req1 bits set and req0 bits clear
		req1_d = '0;
		req0_d = mt;
		flip_d = mt;
		case (gate_code)
			G_CNOT, G_CZ, G_CY: begin
				req1_d = mc;
				op_d   = (gate_code == G_CNOT) ? G_X : ((gate_code == G_CZ) ? G_Z : G_Y);
			end
			G_SWAP: begin
				req1_d = mt; req0_d = mt2; flip_d = mt | mt2; op_d = G_X;
			end
			G_TOF: begin
				req1_d = mc | mc2; op_d = G_X;
			end
			G_FRED: begin
				req1_d = mc | mt; req0_d = mt2; flip_d = mt | mt2; op_d = G_X;
			end
			default: begin
			end
		endcase
	end

	assign is_pair = ((i_q & req1_q) == req1_q) && ((i_q & req0_q) == '0);
	assign last_i  = (i_q == last_q);

	// shared multiplier operand selection
	assign tsel = j_q[2:0];
	always_comb begin
		term = pair_term(op_q, tsel);
		case (term.xs)
			X_ZERO:  xv = '0;
			X_ONE:   xv = ONE_FX;
			X_MONE:  xv = -ONE_FX;
			X_C:     xv = c_q;
			X_S:     xv = s_q;
			X_NS:    xv = -s_q;
			X_K:     xv = K_FX;
			default: xv = -K_FX;
		endcase
		case (term.ys)
			Y_AR:    yv = ar_q;
			Y_AI:    yv = ai_q;
			Y_BR:    yv = br_q;
			default: yv = bi_q;
		endcase
		xe = PW'(xv);
		ye = PW'(yv);
	end

	// sum of two products, round half up, floor shift, saturate
	always_comb begin
		sum = SW'(acc_q) + SW'(prod_q) + HALF;
		shv = sum >>> FRAC_BITS;
		if (shv > AMAX) begin
			rnd = AMAX[AMP_WIDTH-1:0];
		end else if (shv < AMIN) begin
			rnd = AMIN[AMP_WIDTH-1:0];
		end else begin
			rnd = shv[AMP_WIDTH-1:0];
		end
	end

	// memory port muxing
	always_comb begin
		we    = 1'b0;
		waddr = a_q;
		wdata = {res_q[0], res_q[1]};
		raddr = a_q;
		if (state_q == ST_IDLE) begin
			we    = accept && kind == K_LOAD;
			waddr = amp_index;
			wdata = {load_re, load_im};
			raddr = amp_index;
		end else if (state_q == ST_WRA) begin
			we = 1'b1;
		end else if (state_q == ST_WRB) begin
			we    = 1'b1;
			waddr = b_q;
			wdata = {res_q[2], res_q[3]};
		end else if (state_q == ST_RDB) begin
			raddr = b_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nq_cfg_q <= NQW'(MAX_QUBITS);
		end else if (cfg_we) begin
			nq_cfg_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			j_q         <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (kind)
							K_LOAD: begin
								out_valid_q <= 1'b1;
							end
							K_READ: begin
								state_q <= ST_RDW;
							end
							K_GATE: begin
								if (err || gate_code == G_I) begin
									out_valid_q <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (is_pair) begin
						state_q <= ST_RDA;
					end else if (last_i) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				ST_RDA:  state_q <= ST_RDB;
				ST_RDB:  state_q <= ST_CAPB;
				ST_CAPB: begin
					state_q <= ST_MUL;
					j_q     <= '0;
				end
				ST_MUL: begin
					j_q <= j_q + 4'd1;
					if (j_q == 4'd8) state_q <= ST_WRA;
				end
				ST_WRA:  state_q <= ST_WRB;
				ST_WRB: begin
					if (last_i) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_RDW: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			read_re_q <= '0;
			read_im_q <= '0;
			status_q  <= (kind == K_GATE) ? err : (kind != K_LOAD && kind != K_READ);
			op_q      <= op_d;
			c_q       <= CW'(coef_cos);
			s_q       <= s_in;
			req1_q    <= req1_d;
			req0_q    <= req0_d;
			flip_q    <= flip_d;
			last_q    <= last_w[QW-1:0];
			i_q       <= '0;
		end
		if (state_q == ST_SCAN) begin
			a_q <= i_q;
			b_q <= i_q ^ flip_q;
			if (!is_pair && !last_i) i_q <= i_q + QW'(1);
		end
		if (state_q == ST_WRB && !last_i) i_q <= i_q + QW'(1);
		if (state_q == ST_RDB) begin
			ar_q <= rd_q[2*AMP_WIDTH-1:AMP_WIDTH];
			ai_q <= rd_q[AMP_WIDTH-1:0];
		end
		if (state_q == ST_CAPB) begin
			br_q <= rd_q[2*AMP_WIDTH-1:AMP_WIDTH];
			bi_q <= rd_q[AMP_WIDTH-1:0];
		end
		if (state_q == ST_MUL) begin
			if (j_q != 4'd8) prod_q <= xe * ye;
			if (j_q != 4'd0) begin
				if (j_q[0]) acc_q <= prod_q;
				else res_q[j_q[2:1] - 2'd1] <= rnd;
			end
		end
		if (state_q == ST_RDW) begin
			read_re_q <= rd_q[2*AMP_WIDTH-1:AMP_WIDTH];
			read_im_q <= rd_q[AMP_WIDTH-1:0];
			status_q  <= 1'b0;
		end
	end
endmodule
`default_nettype wire

/* sv/svge_checker.sv */
// Port-level checks for the state vector gate engine, bound to the top level
`default_nettype none
`include "state_vector_gate_engine_defines.svh"
module svge_port_checks import svge_pkg::*; (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic [1:0]                  kind,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic signed [AMP_WIDTH-1:0] read_re,
	input wire logic                        status
);
	`SVGE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(read_re))
	`SVGE_ASSERT_NOW(a_busy_on_result, clk, arst_n, out_valid, in_stall)
	`SVGE_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && !in_stall, in_stall)
	`SVGE_ASSERT_NEXT(a_load_done, clk, arst_n, in_valid && !in_stall && kind == K_LOAD, out_valid && !status && read_re == '0)
endmodule

bind state_vector_gate_engine svge_port_checks u_svge_port_checks (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
	.out_valid(out_valid), .out_stall(out_stall), .read_re(read_re), .status(status)
);
`default_nettype wire
